/* src/sfc_pkg.sv */
// Shared types and constants of the sphere/frustum culling block.
// Depends on nothing; used by sfc_cell and sphere_frustum_cull.
package sfc_pkg;

    // Field widths
    localparam int PLANE_COUNT = 6;
    localparam int COEF_W      = 16;   // signed Q7.8 plane coefficient
    localparam int POS_W       = 24;   // signed Q15.8 coordinate
    localparam int RAD_W       = 23;   // unsigned Q15.8 radius
    localparam int PROD_W      = COEF_W + POS_W;       // one product, Q23.16
    localparam int BIAS_W      = RAD_W + 2;            // d + radius, Q.8
    localparam int FRAC_W      = 8;                    // scale of d and radius to Q.16
    localparam int SUM_W       = PROD_W + 2;           // exact plane value plus radius
    localparam int PLANE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4 * COEF_W;

    // Configuration register indexes, also the plane numbers reported
    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_BOTTOM = 3'd2,
        PLANE_TOP    = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } plane_reg_t;

    // Input item
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [RAD_W-1:0]        radius;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic               inside_res;
        logic [PLANE_W-1:0] reject_plane;
    } out_item_t;

    // What moves from one cell to the next each cycle
    typedef struct packed {
        logic               valid;
        logic               rejected;
        logic [PLANE_W-1:0] plane;
        in_item_t           item;
    } cell_bus_t;

    // Register write as seen by every cell
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

/* src/sfc_cell.sv */
// One plane of the culling chain: holds that plane's coefficients and tests
// the passing item in two register stages. Depends on sfc_pkg.
module sfc_cell #(
    parameter sfc_pkg::plane_reg_t PLANE_IDX = sfc_pkg::PLANE_LEFT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfc_pkg::cfg_wr_t   cfg,
    input  sfc_pkg::cell_bus_t bus_in,
    output sfc_pkg::cell_bus_t bus_out
);

    logic [sfc_pkg::CFG_DATA_W-1:0] coef_reg;

    logic signed [sfc_pkg::COEF_W-1:0] coef_a;
    logic signed [sfc_pkg::COEF_W-1:0] coef_b;
    logic signed [sfc_pkg::COEF_W-1:0] coef_c;
    logic signed [sfc_pkg::COEF_W-1:0] coef_d;

    // Stage A registers
    logic                               a_valid_reg;
    sfc_pkg::cell_bus_t                 a_bus_reg;
    logic signed [sfc_pkg::PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [sfc_pkg::PROD_W-1:0]  prod_y_reg, prod_y_next;
    logic signed [sfc_pkg::PROD_W-1:0]  prod_z_reg, prod_z_next;
    logic signed [sfc_pkg::BIAS_W-1:0]  bias_reg, bias_next;

    // Stage B registers
    logic                               b_valid_reg;
    sfc_pkg::cell_bus_t                 b_bus_reg, b_bus_next;
    logic signed [sfc_pkg::SUM_W-1:0]   sum;
    logic                               hit;

    // Coefficient register; the user must write it only while the block is idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg.we && (cfg.index == PLANE_IDX))
        begin
            coef_reg <= cfg.data;
        end
    end

    assign coef_a = coef_reg[1*sfc_pkg::COEF_W-1:0*sfc_pkg::COEF_W];
    assign coef_b = coef_reg[2*sfc_pkg::COEF_W-1:1*sfc_pkg::COEF_W];
    assign coef_c = coef_reg[3*sfc_pkg::COEF_W-1:2*sfc_pkg::COEF_W];
    assign coef_d = coef_reg[4*sfc_pkg::COEF_W-1:3*sfc_pkg::COEF_W];

    // Stage A: three products, d + radius in Q.8
    always_comb
    begin
        prod_x_next = coef_a * bus_in.item.pos_x;
        prod_y_next = coef_b * bus_in.item.pos_y;
        prod_z_next = coef_c * bus_in.item.pos_z;
        bias_next   = {{(sfc_pkg::BIAS_W-sfc_pkg::COEF_W){coef_d[sfc_pkg::COEF_W-1]}}, coef_d}
                    + {2'b00, bus_in.item.radius};
    end

    // Stage B: s + r <= 0 rejects; the first rejecting plane is kept
    always_comb
    begin
        sum = {{(sfc_pkg::SUM_W-sfc_pkg::PROD_W){prod_x_reg[sfc_pkg::PROD_W-1]}}, prod_x_reg}
            + {{(sfc_pkg::SUM_W-sfc_pkg::PROD_W){prod_y_reg[sfc_pkg::PROD_W-1]}}, prod_y_reg}
            + {{(sfc_pkg::SUM_W-sfc_pkg::PROD_W){prod_z_reg[sfc_pkg::PROD_W-1]}}, prod_z_reg}
            + {{(sfc_pkg::SUM_W-sfc_pkg::BIAS_W-sfc_pkg::FRAC_W){bias_reg[sfc_pkg::BIAS_W-1]}},
               bias_reg, {sfc_pkg::FRAC_W{1'b0}}};
        hit = sum[sfc_pkg::SUM_W-1] || (sum == '0);

        b_bus_next       = a_bus_reg;
        b_bus_next.valid = a_valid_reg;
        if (!a_bus_reg.rejected && hit)
        begin
            b_bus_next.rejected = 1'b1;
            b_bus_next.plane    = PLANE_IDX;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= bus_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        a_bus_reg  <= bus_in;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        bias_reg   <= bias_next;
        b_bus_reg  <= b_bus_next;
    end

    always_comb
    begin
        bus_out       = b_bus_reg;
        bus_out.valid = b_valid_reg;
    end

endmodule

/* src/sphere_frustum_cull.sv */
// Top level of the sphere/frustum culling block: six plane cells in a chain.
// Depends on sfc_pkg and sfc_cell.
//
//   channel   handshake              payload
//   --------  ---------------------  --------------------------------
//   input     start / busy           item   (sfc_pkg::in_item_t)
//   result    done (one-cycle)       result (sfc_pkg::out_item_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock; each item passes through two register stages (products, then sum
// and compare) in each of six cells. busy is always low and cfg_ready always high.
// Reset clears the valid bits and sets every plane register to zero. The receiver
// cannot stall, so no back-pressure exists anywhere in the chain.
module sphere_frustum_cull (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfc_pkg::in_item_t              item,
    output logic                           done,
    output sfc_pkg::out_item_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LATENCY = 2 * sfc_pkg::PLANE_COUNT;

    sfc_pkg::cell_bus_t bus [sfc_pkg::PLANE_COUNT+1];
    sfc_pkg::cfg_wr_t   cfg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register write, broadcast to all cells
    always_comb
    begin
        cfg.we    = cfg_valid && cfg_ready;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    // Chain entry
    always_comb
    begin
        bus[0].valid    = start && !busy;
        bus[0].rejected = 1'b0;
        bus[0].plane    = '0;
        bus[0].item     = item;
    end

    // One cell per plane, left to far
    for (genvar g = 0; g < sfc_pkg::PLANE_COUNT; g++)
    begin : g_cell
        sfc_cell #(
            .PLANE_IDX (sfc_pkg::plane_reg_t'(g))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg),
            .bus_in  (bus[g]),
            .bus_out (bus[g+1])
        );
    end

    // Result from the last cell's register
    always_comb
    begin
        done                = bus[sfc_pkg::PLANE_COUNT].valid;
        result.inside_res   = !bus[sfc_pkg::PLANE_COUNT].rejected;
        result.reject_plane = bus[sfc_pkg::PLANE_COUNT].rejected
                            ? bus[sfc_pkg::PLANE_COUNT].plane : '0;
    end

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item taken but no result after the chain latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result with no item taken one chain latency earlier");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.inside_res) |->
            (result.reject_plane < sfc_pkg::PLANE_W'(sfc_pkg::PLANE_COUNT)))
        else $error("rejecting plane out of range");
`endif

endmodule

/* test/sphere_frustum_cull_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sphere_frustum_cull: a directed table, then random spheres
// under several plane settings, each result checked against a typed table verdict or an
// in-bench culling predictor. Depends on sfc_pkg and the sphere_frustum_cull RTL.
module sphere_frustum_cull_tb;

    import sfc_pkg::*;

    localparam int LATENCY     = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ONE         = 256;                // 1.0 in Q15.8
    localparam int POS_MIN     = -(1 << 23);
    localparam int POS_MAX     = (1 << 23) - 1;
    localparam int RAD_MAX     = (1 << 23) - 1;
    localparam int PHASE_ITEMS = 107;
    localparam int DIR_N       = 22;

    // Register indexes past the last plane; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

    // Plane settings loaded between phases
    typedef enum int {
        CFG_KEEP,
        CFG_ZERO,
        CFG_FRUSTUM,
        CFG_EXT_POS,
        CFG_EXT_NEG,
        CFG_RANDOM
    } cfg_set_t;

    // One directed row: setting to load first, the sphere, and an optional typed verdict
    typedef struct {
        cfg_set_t   cfg;
        int         px;
        int         py;
        int         pz;
        int         rad;
        bit         typed;
        bit         ins;
        plane_reg_t pl;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    in_item_t              item      = '0;
    logic                  done;
    out_item_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [CFG_DATA_W-1:0] plane_coef [PLANE_COUNT] = '{default: '0};
    out_item_t             verdict_q [$];
    out_item_t             oldest;
    int                    mismatches = 0;
    int                    cycles     = 0;

    dir_row_t dir_rows [DIR_N] = '{
        // zero planes after reset
        '{CFG_KEEP,    0,        0,        0,        0,           1, 0, PLANE_LEFT},
        '{CFG_KEEP,    0,        0,        0,        1,           1, 1, PLANE_LEFT},
        '{CFG_KEEP,    POS_MIN,  POS_MIN,  POS_MIN,  0,           1, 0, PLANE_LEFT},
        '{CFG_KEEP,    POS_MAX,  POS_MAX,  POS_MAX,  RAD_MAX,     1, 1, PLANE_LEFT},
        // box |x|,|y| < 16, 1 < z < 64
        '{CFG_FRUSTUM, 0,        0,        8*ONE,    0,           1, 1, PLANE_LEFT},
        '{CFG_KEEP,    -20*ONE,  0,        8*ONE,    0,           1, 0, PLANE_LEFT},
        '{CFG_KEEP,    -20*ONE,  0,        8*ONE,    4*ONE,       1, 0, PLANE_LEFT},
        '{CFG_KEEP,    -20*ONE,  0,        8*ONE,    4*ONE + 1,   1, 1, PLANE_LEFT},
        '{CFG_KEEP,    20*ONE,   0,        8*ONE,    0,           1, 0, PLANE_RIGHT},
        '{CFG_KEEP,    0,        -20*ONE,  8*ONE,    0,           1, 0, PLANE_BOTTOM},
        '{CFG_KEEP,    0,        20*ONE,   8*ONE,    0,           1, 0, PLANE_TOP},
        '{CFG_KEEP,    0,        0,        ONE,      0,           1, 0, PLANE_NEAR},
        '{CFG_KEEP,    0,        0,        100*ONE,  0,           1, 0, PLANE_FAR},
        '{CFG_KEEP,    0,        0,        100*ONE,  36*ONE,      1, 0, PLANE_FAR},
        '{CFG_KEEP,    16*ONE,   16*ONE,   64*ONE,   0,           1, 0, PLANE_RIGHT},
        // extreme coefficients against extreme coordinates
        '{CFG_EXT_POS, POS_MAX,  POS_MAX,  POS_MAX,  0,           0, 0, PLANE_LEFT},
        '{CFG_KEEP,    POS_MIN,  POS_MIN,  POS_MIN,  0,           0, 0, PLANE_LEFT},
        '{CFG_KEEP,    POS_MIN,  POS_MAX,  POS_MIN,  RAD_MAX,     0, 0, PLANE_LEFT},
        '{CFG_EXT_NEG, POS_MAX,  POS_MAX,  POS_MAX,  0,           0, 0, PLANE_LEFT},
        '{CFG_KEEP,    POS_MIN,  POS_MIN,  POS_MIN,  RAD_MAX,     0, 0, PLANE_LEFT},
        // planes written back to zero
        '{CFG_ZERO,    5,        -7,       3,        0,           1, 0, PLANE_LEFT},
        '{CFG_KEEP,    5,        -7,       3,        RAD_MAX,     1, 1, PLANE_LEFT}
    };

    cfg_set_t rand_plan [8] = '{CFG_FRUSTUM, CFG_RANDOM, CFG_EXT_NEG, CFG_RANDOM,
                                CFG_ZERO, CFG_FRUSTUM, CFG_EXT_POS, CFG_RANDOM};

    sphere_frustum_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Culling verdict: first plane where a*x + b*y + c*z + d <= -radius, exact in 64 bits
    function automatic out_item_t classify_sphere(in_item_t it);
        longint            px;
        longint            py;
        longint            pz;
        longint            rad;
        longint            plane_s;
        logic signed [15:0] ca;
        logic signed [15:0] cb;
        logic signed [15:0] cc;
        logic signed [15:0] cd;
        out_item_t         v;
        px  = longint'(it.pos_x);
        py  = longint'(it.pos_y);
        pz  = longint'(it.pos_z);
        rad = it.radius;
        rad = rad * 256;
        v.inside_res   = 1'b1;
        v.reject_plane = PLANE_LEFT;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            ca      = plane_coef[p][15:0];
            cb      = plane_coef[p][31:16];
            cc      = plane_coef[p][47:32];
            cd      = plane_coef[p][63:48];
            plane_s = ca * px + cb * py + cc * pz + cd * 256;
            if (v.inside_res && plane_s <= -rad)
            begin
                v.inside_res   = 1'b0;
                v.reject_plane = 3'(p);
            end
        end
        return v;
    endfunction

    function automatic in_item_t mk_item(int x, int y, int z, int r);
        in_item_t it;
        it.pos_x  = x[23:0];
        it.pos_y  = y[23:0];
        it.pos_z  = z[23:0];
        it.radius = r[22:0];
        return it;
    endfunction

    // Mix of full-range, small and near-the-box centres so every plane gets to reject
    function automatic in_item_t rand_sphere();
        int x;
        int y;
        int z;
        int r;
        case ($urandom_range(0, 2))
            0:
            begin
                x = int'($urandom());
                y = int'($urandom());
                z = int'($urandom());
            end
            1:
            begin
                x = int'($urandom_range(0, 64*ONE)) - 32*ONE;
                y = int'($urandom_range(0, 64*ONE)) - 32*ONE;
                z = int'($urandom_range(0, 64*ONE)) - 32*ONE;
            end
            default:
            begin
                x = int'($urandom_range(0, 48*ONE)) - 24*ONE;
                y = int'($urandom_range(0, 48*ONE)) - 24*ONE;
                z = int'($urandom_range(0, 80*ONE)) - 8*ONE;
            end
        endcase
        case ($urandom_range(0, 3))
            0:       r = 0;
            1:       r = int'($urandom_range(0, 2*ONE));
            2:       r = int'($urandom());
            default: r = int'($urandom_range(0, 40*ONE));
        endcase
        return mk_item(x, y, z, r);
    endfunction

    // Register contents of plane p under a setting; {d, c, b, a}
    function automatic logic [CFG_DATA_W-1:0] setting_value(cfg_set_t s, int p);
        case (s)
            CFG_FRUSTUM:
                case (p)
                    PLANE_LEFT:   return 64'h1000_0000_0000_0100;
                    PLANE_RIGHT:  return 64'h1000_0000_0000_FF00;
                    PLANE_BOTTOM: return 64'h1000_0000_0100_0000;
                    PLANE_TOP:    return 64'h1000_0000_FF00_0000;
                    PLANE_NEAR:   return 64'hFF00_0100_0000_0000;
                    default:      return 64'h4000_FF00_0000_0000;
                endcase
            CFG_EXT_POS: return 64'h7FFF_7FFF_7FFF_7FFF;
            CFG_EXT_NEG: return 64'h8000_8000_8000_8000;
            CFG_RANDOM:  return {$urandom(), $urandom()};
            default:     return '0;
        endcase
    endfunction

    // Wait at the falling edge until every verdict is back, then resync to the rising edge
    task automatic drain();
        start <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one item, hold until taken, then queue its verdict
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_v);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        verdict_q.push_back(typed ? typed_v : classify_sphere(it));
    endtask

    // cfg_valid is left high; the caller lowers it after the last write
    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < PLANE_COUNT)
            plane_coef[idx] = val;
    endtask

    task automatic load_setting(cfg_set_t s);
        drain();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_plane(3'(p), setting_value(s, p));
        if (s == CFG_FRUSTUM)
        begin
            write_plane(IDX_SPARE_6, {$urandom(), $urandom()});
            write_plane(IDX_SPARE_7, {$urandom(), $urandom()});
        end
        cfg_valid <= 1'b0;
    endtask

    // Result checker and run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual inside=%0d plane=%0d",
                         $time, result.inside_res, result.reject_plane);
                mismatches = mismatches + 1;
            end
            else
            begin
                oldest = verdict_q.pop_front();
                if (result.inside_res !== oldest.inside_res)
                begin
                    $display("%0t: inside_res expected %0d actual %0d",
                             $time, oldest.inside_res, result.inside_res);
                    mismatches = mismatches + 1;
                end
                if (result.reject_plane !== oldest.reject_plane)
                begin
                    $display("%0t: reject_plane expected %0d actual %0d",
                             $time, oldest.reject_plane, result.reject_plane);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int burst;
        int gap;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != CFG_KEEP)
                load_setting(dir_rows[i].cfg);
            send_item(mk_item(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                              dir_rows[i].rad),
                      dir_rows[i].typed, '{dir_rows[i].ins, dir_rows[i].pl});
            pause($urandom_range(0, 2));
        end

        // random spheres, bursts with random gaps, one full drain mid-phase
        foreach (rand_plan[ph])
        begin
            load_setting(rand_plan[ph]);
            burst = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_item(rand_sphere(), 1'b0, '0);
                burst--;
                if (burst == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    pause(gap);
                    burst = $urandom_range(1, 40);
                end
            end
        end

        drain();
        repeat (3 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
